// File: hdl/wmps_pkg.sv
// Package for the weighted multi-pattern scorer: sizes, modes, command types.
// No dependencies.
package wmps_pkg;
  localparam int NumPatterns = 64;
  localparam int MaxPatLen   = 16;
  localparam int IdxW   = 6;
  localparam int PosW   = 4;
  localparam int LenW   = 5;
  localparam int WgtW   = 24;
  localparam int TotW   = 48;
  localparam int CharAddrW = IdxW + PosW;
  localparam int CharDepth = NumPatterns * MaxPatLen;

  localparam logic [1:0] ModeChar  = 2'd0;
  localparam logic [1:0] ModeLen   = 2'd1;
  localparam logic [1:0] ModeStart = 2'd2;
  localparam logic [1:0] ModeStrand = 2'd3;

  localparam logic [TotW-1:0] TotalMax = {TotW{1'b1}};

  // controller to datapath commands
  typedef struct packed {
    logic             shift_char;  // push strand char into history
    logic             start;       // load range, clear strand
    logic             load_p;      // load scan pointer from range_first
    logic             rd_pat;      // start reads of pattern p from char 0 (clears k)
    logic             cmp_step;    // advance compare pointer to next char
    logic             add;         // add weight of pattern p
    logic             next_p;      // advance pattern pointer
    logic             finish;      // update min/max, capture result
    logic             clr_strand;  // clear total after result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic p_done;     // pointer beyond range or table
    logic len_ok;     // length valid and fits chars seen
    logic cmp_last;   // compare pointer at last char
    logic mismatch;   // current char differs
  } stat_t;
endpackage

// File: hdl/wmps_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module wmps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/wmps_datapath.sv
// Datapath: pattern memories, strand history, scan pointer, totals.
// Depends on wmps_pkg and wmps_ram.
module wmps_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  wmps_pkg::cmd_t            cmd,
  output wmps_pkg::stat_t           stat,
  // load interface, taken directly when accepted
  input  logic                      in_fire,
  input  logic [1:0]                mode,
  input  logic [wmps_pkg::IdxW-1:0] pattern_index,
  input  logic [wmps_pkg::PosW-1:0] char_pos,
  input  logic [7:0]                char_value,
  input  logic [wmps_pkg::LenW-1:0] pattern_length,
  input  logic [wmps_pkg::WgtW-1:0] pattern_weight,
  input  logic [wmps_pkg::IdxW-1:0] range_first,
  input  logic [wmps_pkg::IdxW-1:0] range_last,
  output logic [wmps_pkg::TotW-1:0] strand_total,
  output logic [wmps_pkg::TotW-1:0] lowest_total,
  output logic [wmps_pkg::TotW-1:0] highest_total,
  output logic                      saturated
);
  localparam int TotW = wmps_pkg::TotW;

  logic [7:0]                 recent [wmps_pkg::MaxPatLen];
  logic [wmps_pkg::LenW-1:0]  chars_seen;
  logic [wmps_pkg::IdxW-1:0]  active_first, active_last;
  logic [wmps_pkg::IdxW:0]    p;          // one bit more to step past 63
  logic [wmps_pkg::PosW-1:0]  k;
  logic [TotW-1:0]            total, min_t, max_t;
  logic                       sat;
  logic [wmps_pkg::LenW-1:0]  len_rd;
  logic [wmps_pkg::WgtW-1:0]  wgt_rd;
  logic [7:0]                 chr_rd;
  logic [TotW:0]              sum;
  logic [wmps_pkg::LenW-1:0]  hist_idx;

  // pattern memories
  wmps_ram #(.Width(8), .Depth(wmps_pkg::CharDepth)) u_chars (
    .clk, .we(in_fire && mode == wmps_pkg::ModeChar),
    .waddr({pattern_index, char_pos}), .wdata(char_value),
    .raddr({p[wmps_pkg::IdxW-1:0], k}), .rdata(chr_rd));
  wmps_ram #(.Width(wmps_pkg::LenW), .Depth(wmps_pkg::NumPatterns)) u_lens (
    .clk, .we(in_fire && mode == wmps_pkg::ModeLen),
    .waddr(pattern_index), .wdata(pattern_length),
    .raddr(p[wmps_pkg::IdxW-1:0]), .rdata(len_rd));
  wmps_ram #(.Width(wmps_pkg::WgtW), .Depth(wmps_pkg::NumPatterns)) u_wgts (
    .clk, .we(in_fire && mode == wmps_pkg::ModeLen),
    .waddr(pattern_index), .wdata(pattern_weight),
    .raddr(p[wmps_pkg::IdxW-1:0]), .rdata(wgt_rd));

  // status: pattern char k compares with recent[len-1-k]
  assign hist_idx = len_rd - 5'd1 - {1'b0, k};
  assign stat.p_done = (p > {1'b0, active_last});
  assign stat.len_ok = (len_rd != '0) && (len_rd <= 5'(wmps_pkg::MaxPatLen))
                       && (len_rd <= chars_seen);
  assign stat.cmp_last = ({1'b0, k} == len_rd - 5'd1);
  assign stat.mismatch = chr_rd != recent[hist_idx[wmps_pkg::PosW-1:0]];
  assign sum = {1'b0, total} + {{(TotW-wmps_pkg::WgtW+1){1'b0}}, wgt_rd};

  // history shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wmps_pkg::MaxPatLen; i++) recent[i] <= '0;
    end else if (cmd.shift_char) begin
      recent[0] <= char_value;
      for (int i = 1; i < wmps_pkg::MaxPatLen; i++) recent[i] <= recent[i-1];
    end
  end

  // strand state and scan pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_seen <= '0; active_first <= '0; active_last <= '0;
      total <= '0; sat <= 1'b0; min_t <= wmps_pkg::TotalMax; max_t <= '0;
      p <= '0; k <= '0;
    end else begin
      if (cmd.start) begin
        active_first <= range_first; active_last <= range_last;
        chars_seen <= '0; total <= '0; sat <= 1'b0;
      end
      if (cmd.shift_char && chars_seen < 5'(wmps_pkg::MaxPatLen)) begin
        chars_seen <= chars_seen + 5'd1;
      end
      if (cmd.load_p) p <= {1'b0, active_first};
      if (cmd.next_p) p <= p + 7'd1;
      if (cmd.rd_pat) k <= '0;
      else if (cmd.cmp_step) k <= k + 4'd1;
      if (cmd.add) begin
        if (sum[TotW]) begin
          total <= wmps_pkg::TotalMax; sat <= 1'b1;
        end else begin
          total <= sum[TotW-1:0];
        end
      end
      if (cmd.finish) begin
        if (total < min_t) min_t <= total;
        if (total > max_t) max_t <= total;
      end
      if (cmd.clr_strand) begin
        total <= '0; chars_seen <= '0; sat <= 1'b0;
      end
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      strand_total  <= total;
      lowest_total  <= (total < min_t) ? total : min_t;
      highest_total <= (total > max_t) ? total : max_t;
      saturated     <= sat;
    end
  end
endmodule

// File: hdl/wmps_ctrl.sv
// Controller: accepts requests, sequences the pattern scan, hands out results.
// Depends on wmps_pkg.
module wmps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      mode,
  input  logic            end_of_strand,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output wmps_pkg::cmd_t  cmd,
  input  wmps_pkg::stat_t stat
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_READ = 7'b0000100,
    S_WAIT = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_ADD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   eos, eos_next, out_next;
  logic   fire;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign fire = in_valid && in_ready;

  always_comb begin
    state_next = state;
    eos_next = eos;
    out_next = out_valid && !out_ready;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (fire) begin
          if (mode == wmps_pkg::ModeStart) cmd.start = 1'b1;
          if (mode == wmps_pkg::ModeStrand) begin
            cmd.shift_char = 1'b1;
            eos_next = end_of_strand;
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load_p = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        // memories read address p, k reset to 0
        cmd.rd_pat = 1'b1;
        state_next = stat.p_done ? S_FIN : S_WAIT;
      end
      S_WAIT: begin
        if (!stat.len_ok) begin
          cmd.next_p = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.mismatch) begin
          cmd.next_p = 1'b1;
          state_next = S_READ;
        end else if (stat.cmp_last) begin
          state_next = S_ADD;
        end else begin
          // advance k; the next char is read in S_WAIT
          cmd.cmp_step = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        cmd.next_p = 1'b1;
        state_next = S_READ;
      end
      S_FIN: begin
        if (eos) begin
          cmd.finish = 1'b1;
          cmd.clr_strand = 1'b1;
          out_next = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; eos <= 1'b0; out_valid <= 1'b0;
    end else begin
      state <= state_next; eos <= eos_next; out_valid <= out_next;
    end
  end
endmodule

// File: hdl/weighted_multi_pattern_scorer.sv
// Top level of the weighted multi-pattern scorer.
// Depends on wmps_pkg, wmps_ctrl, wmps_datapath.
//
// Slave channel s_axis_* carries requests: pattern char loads (mode 0),
// pattern length/weight loads (mode 1), strand starts (mode 2) and strand
// characters (mode 3, tlast marks the end of strand). Loads and starts are
// taken in the idle state. A strand character scans the active index range
// one pattern at a time through the shared pattern memories: a pattern is
// rejected on length or compared one character at a time (a mismatch ends
// it early), and on a full match its weight is added. Pointer load, end
// check and finish surround the scan; no new request is accepted until the
// scan is done.
// On the last character one result appears on m_axis_* the cycle after the
// finish step; tdata holds total, minimum and maximum, tuser the saturation
// flag. A result is held until taken; no new request is accepted meanwhile.
// rst (synchronous) clears history, range, totals, minimum (to all ones) and
// maximum; pattern memories are not cleared.
module weighted_multi_pattern_scorer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: mode[1:0], pattern_index[7:2], char_pos[11:8], char_value[19:12],
  // pattern_length[24:20], pattern_weight[48:25], range_first[54:49],
  // range_last[60:55], zero pad [63:61]
  input  logic [63:0]  s_axis_tdata,
  input  logic         s_axis_tlast,   // end_of_strand
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: strand_total[47:0], lowest_total[95:48], highest_total[143:96]
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tuser,   // saturated
  output logic         m_axis_tlast
);
  wmps_pkg::cmd_t  cmd;
  wmps_pkg::stat_t stat;
  logic [1:0] mode;

  assign mode = s_axis_tdata[1:0];
  assign m_axis_tlast = 1'b1;

  wmps_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .mode,
    .end_of_strand(s_axis_tlast), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd, .stat);

  wmps_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_fire(s_axis_tvalid && s_axis_tready), .mode,
    .pattern_index(s_axis_tdata[7:2]), .char_pos(s_axis_tdata[11:8]),
    .char_value(s_axis_tdata[19:12]), .pattern_length(s_axis_tdata[24:20]),
    .pattern_weight(s_axis_tdata[48:25]), .range_first(s_axis_tdata[54:49]),
    .range_last(s_axis_tdata[60:55]),
    .strand_total(m_axis_tdata[47:0]), .lowest_total(m_axis_tdata[95:48]),
    .highest_total(m_axis_tdata[143:96]), .saturated(m_axis_tuser));

  // result ordering: minimum never exceeds total, total never exceeds maximum
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[95:48] <= m_axis_tdata[47:0])
                   && (m_axis_tdata[47:0] <= m_axis_tdata[143:96]))
    else $error("min/total/max out of order");
  // saturation flag only with the limit value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:0] == wmps_pkg::TotalMax)
    else $error("saturation flag without full total");
  // no request taken while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request accepted while result pending");
endmodule

// File: test/wmps_checker.sv
// Checker for the weighted multi-pattern scorer: watches both stream channels,
// predicts strand scores from accepted requests and compares each result.
// Depends on wmps_pkg.
module wmps_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_valid,
  input  logic         s_ready,
  input  logic [63:0]  s_data,
  input  logic         s_last,
  input  logic         m_valid,
  input  logic         m_ready,
  input  logic [143:0] m_data,
  input  logic         m_user,
  output int           fails,
  output int           pending
);

  typedef struct packed {
    logic [wmps_pkg::TotW-1:0] total;
    logic [wmps_pkg::TotW-1:0] lowest;
    logic [wmps_pkg::TotW-1:0] highest;
    logic                      sat;
  } score_t;

  // shadow copy of the pattern table and strand state
  logic [7:0]                pat_chr [wmps_pkg::NumPatterns][wmps_pkg::MaxPatLen];
  logic [wmps_pkg::LenW-1:0] pat_len [wmps_pkg::NumPatterns];
  logic [wmps_pkg::WgtW-1:0] pat_wgt [wmps_pkg::NumPatterns];
  logic [7:0]                hist [wmps_pkg::MaxPatLen];
  int                        seen;
  logic [wmps_pkg::IdxW-1:0] act_first, act_last;
  logic [wmps_pkg::TotW-1:0] total, lowest, highest;
  logic                      sat;
  score_t                    scores_due [$];

  assign pending = scores_due.size();

  // state after reset
  task automatic reset_model();
    fails = 0;
    seen = 0;
    act_first = '0; act_last = '0;
    total = '0; lowest = wmps_pkg::TotalMax; highest = '0; sat = 1'b0;
    for (int k = 0; k < wmps_pkg::MaxPatLen; k++) hist[k] = '0;
    for (int p = 0; p < wmps_pkg::NumPatterns; p++) begin
      pat_len[p] = '0;
      pat_wgt[p] = '0;
    end
  endtask

  // work out the effect of one accepted request
  task automatic apply_request(input logic [63:0] d, input logic last);
    logic [1:0]                md;
    logic [wmps_pkg::IdxW-1:0] idx;
    logic [wmps_pkg::TotW:0]   sum;
    logic                      hit;
    int                        len;
    score_t                    sc;
    md  = d[1:0];
    idx = d[7:2];
    case (md)
      wmps_pkg::ModeChar: begin
        pat_chr[idx][d[11:8]] = d[19:12];
      end
      wmps_pkg::ModeLen: begin
        pat_len[idx] = d[24:20];
        pat_wgt[idx] = d[48:25];
      end
      wmps_pkg::ModeStart: begin
        act_first = d[54:49];
        act_last  = d[60:55];
        seen  = 0;
        total = '0;
        sat   = 1'b0;
      end
      default: begin
        for (int k = wmps_pkg::MaxPatLen - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = d[19:12];
        if (seen < wmps_pkg::MaxPatLen) seen++;
        for (int p = act_first; p <= act_last && p < wmps_pkg::NumPatterns; p++) begin
          len = pat_len[p];
          hit = (len != 0) && (len <= wmps_pkg::MaxPatLen) && (len <= seen);
          for (int k = 0; hit && k < len; k++)
            if (pat_chr[p][k] != hist[len-1-k]) hit = 1'b0;
          if (hit) begin
            sum = {1'b0, total} + pat_wgt[p];
            if (sum > {1'b0, wmps_pkg::TotalMax}) begin
              total = wmps_pkg::TotalMax;
              sat   = 1'b1;
            end else begin
              total = sum[wmps_pkg::TotW-1:0];
            end
          end
        end
        if (last) begin
          if (total < lowest)  lowest  = total;
          if (total > highest) highest = total;
          sc.total = total; sc.lowest = lowest; sc.highest = highest; sc.sat = sat;
          scores_due.insert(scores_due.size(), sc);
          total = '0;
          seen  = 0;
          sat   = 1'b0;
        end
      end
    endcase
  endtask

  // requests in, results out, compared oldest first
  always @(posedge clk) begin
    score_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (m_valid && m_ready) begin
        if (scores_due.size() == 0) begin
          $error("result with no score waiting");
          fails++;
        end else begin
          want = scores_due.pop_front();
          if (m_data[47:0] !== want.total) begin
            $error("strand_total: expected %0h, actual %0h", want.total, m_data[47:0]);
            fails++;
          end
          if (m_data[95:48] !== want.lowest) begin
            $error("lowest_total: expected %0h, actual %0h", want.lowest, m_data[95:48]);
            fails++;
          end
          if (m_data[143:96] !== want.highest) begin
            $error("highest_total: expected %0h, actual %0h", want.highest,
                   m_data[143:96]);
            fails++;
          end
          if (m_user !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, m_user);
            fails++;
          end
        end
      end
      if (s_valid && s_ready) apply_request(s_data, s_last);
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the weighted multi-pattern scorer: clock, reset, request
// stimulus with idling phases and the verdict. Depends on wmps_pkg,
// weighted_multi_pattern_scorer and wmps_checker.
module tb_top;

  localparam int IdleLimit = 40000;

  typedef logic [wmps_pkg::IdxW-1:0] idx_t;
  typedef logic [wmps_pkg::PosW-1:0] pos_t;
  typedef logic [wmps_pkg::LenW-1:0] len_t;
  typedef logic [wmps_pkg::WgtW-1:0] wgt_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  int           fails;
  int           pending;
  int           idle_pct;
  int           stall_pct;
  int           sent;
  int           quiet;
  // which pattern chars have been loaded, so no unwritten entry is ever compared
  logic         chr_ok [wmps_pkg::NumPatterns][wmps_pkg::MaxPatLen];

  weighted_multi_pattern_scorer uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  wmps_checker chk (
    .clk(clk), .rst(rst),
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .s_data(s_axis_tdata), .s_last(s_axis_tlast),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_data(m_axis_tdata), .m_user(m_axis_tuser),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly a two-letter alphabet so that patterns actually match
  function automatic logic [7:0] pick_char();
    if ($urandom_range(9) < 8) return $urandom_range(1) ? 8'h61 : 8'h62;
    return 8'($urandom_range(255));
  endfunction

  // one request, other fields filled with noise
  task automatic send(input logic [1:0] md, input int idx, input int pos,
                      input int cv, input int len, input int wgt,
                      input int rf, input int rl, input int last);
    int   gap;
    idx_t i_idx;
    pos_t i_pos;
    i_idx = idx_t'(idx);
    i_pos = pos_t'(pos);
    s_axis_tdata  <= {3'b000, idx_t'(rl), idx_t'(rf), wgt_t'(wgt), len_t'(len),
                      8'(cv), i_pos, i_idx, md};
    s_axis_tlast  <= last[0];
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    if (md == wmps_pkg::ModeChar) chr_ok[i_idx][i_pos] = 1'b1;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_char(input int idx, input int pos, input int cv);
    send(wmps_pkg::ModeChar, idx, pos, cv, $urandom, $urandom, $urandom, $urandom,
         $urandom);
  endtask

  // set a length, first loading any char of it that is still unwritten
  task automatic load_pattern(input int idx, input int len, input int wgt);
    for (int k = 0; k < len && k < wmps_pkg::MaxPatLen; k++)
      if (!chr_ok[idx][k]) load_char(idx, k, pick_char());
    send(wmps_pkg::ModeLen, idx, $urandom, $urandom, len, wgt, $urandom, $urandom,
         $urandom);
  endtask

  task automatic start_strand(input int rf, input int rl);
    send(wmps_pkg::ModeStart, $urandom, $urandom, $urandom, $urandom, $urandom, rf, rl,
         $urandom);
  endtask

  task automatic strand(input int n, input bit uniform, input int cv);
    for (int k = 0; k < n; k++)
      send(wmps_pkg::ModeStrand, $urandom, $urandom, uniform ? cv : pick_char(),
           $urandom, $urandom, $urandom, $urandom, k == n - 1);
  endtask

  task automatic pick_len(output int len);
    int r;
    r = $urandom_range(99);
    if (r < 75)      len = $urandom_range(1, 4);
    else if (r < 88) len = $urandom_range(5, 16);
    else if (r < 94) len = 0;
    else             len = $urandom_range(17, 31);
  endtask

  initial begin
    int len, r, a, b;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    for (int p = 0; p < wmps_pkg::NumPatterns; p++)
      for (int k = 0; k < wmps_pkg::MaxPatLen; k++) chr_ok[p][k] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // preload every pattern so that any range is legal
    for (int p = 0; p < wmps_pkg::NumPatterns; p++) begin
      pick_len(len);
      load_pattern(p, len, $urandom);
    end

    // directed: chars before any start, extreme weights, longest pattern
    strand(3, 0, 0);
    load_pattern(0, 1, 24'hFFFFFF);
    strand(4, 1, 8'h61);
    for (int k = 0; k < wmps_pkg::MaxPatLen; k++) load_char(5, k, 8'h61);
    load_pattern(5, 16, 24'd0);
    load_pattern(6, 16, 24'hFFFFFF);
    for (int k = 0; k < wmps_pkg::MaxPatLen; k++) load_char(6, k, 8'h61);
    load_pattern(7, 0, 24'hFFFFFF);        // zero length never matches
    load_pattern(8, 31, 24'hFFFFFF);       // length beyond the limit
    start_strand(4, 8);
    strand(20, 1, 8'h61);
    start_strand(9, 3);                    // empty range
    strand(2, 1, 8'h61);
    start_strand(0, 63);
    strand(2, 1, 8'hFF);
    strand(1, 1, 8'h00);                   // new strand over same range

    // random part in four idling phases
    while (sent < 1350) begin
      case ((sent / 300) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      r = $urandom_range(99);
      if (r < 15) begin
        pick_len(len);
        load_pattern($urandom_range(63), len, $urandom);
      end else if (r < 25) begin
        load_char($urandom_range(63), $urandom_range(15), pick_char());
      end else if (r < 30) begin
        strand($urandom_range(1, 3), 0, 0);    // strand without fresh start
      end else if (r < 35) begin
        start_strand($urandom_range(63), $urandom_range(63));  // may be empty
        if ($urandom_range(1)) strand($urandom_range(1, 4), 0, 0);
      end else begin
        a = $urandom_range(63);
        b = ($urandom_range(9) == 0) ? 63 : a + $urandom_range(0, 7);
        if (b > 63) b = 63;
        start_strand(a, b);
        if ($urandom_range(4) == 0) begin
          send(wmps_pkg::ModeStrand, $urandom, $urandom, pick_char(), $urandom,
               $urandom, $urandom, $urandom, 0);
          start_strand(a, b);                  // abandoned strand
        end
        strand($urandom_range(1, 20), 0, 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
